// ===== rtl/lkd_pkg.sv =====
// Package for the three-wire LED driver serial master.
// Holds the configuration and result types, command bytes and function codes.
// Used by every module of the block; depends on nothing.
package lkd_pkg;

	localparam int DISPLAY_BYTES_DEF = 14;
	localparam int KEY_BYTES_DEF     = 5;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_LOAD = 2'd1;
	localparam logic [1:0] FUNC_UPD  = 2'd2;
	localparam logic [1:0] FUNC_KEY  = 2'd3;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_BRIGHT = 2'd1;
	localparam logic [1:0] CFG_LENGTH = 2'd2;

	localparam logic [7:0] CMD_WRITE_AUTO = 8'h40;
	localparam logic [7:0] CMD_ADDR_ZERO  = 8'hC0;
	localparam logic [7:0] CMD_DISP_CTRL  = 8'h80;
	localparam logic [7:0] CMD_KEY_READ   = 8'h42;

	localparam int KEY_IDX_W = 3;
	localparam int RES_W     = 18;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic [7:0] mode_cmd;
		logic [3:0] bright;
		logic [3:0] length;
	} cfg_t;

	typedef struct packed {
		logic [7:0]           key_byte;
		logic [KEY_IDX_W-1:0] key_index;
		logic                 key_valid;
		logic                 rejected;
		logic                 busy_res;
		logic                 stb_level;
		logic                 dio_drive;
		logic                 dio_level;
		logic                 clk_level;
	} res_t;

endpackage

// ===== rtl/lkd_dispbuf.sv =====
// Display buffer memory of the LED driver serial master.
// One write port and one registered read port.
// Depends on lkd_pkg.
module lkd_dispbuf #(
	parameter int DISPLAY_BYTES = lkd_pkg::DISPLAY_BYTES_DEF,
	parameter int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import lkd_pkg::*;

	logic [7:0] mem [DISPLAY_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lkd_seq.sv =====
// Transaction sequencer of the LED driver serial master.
// Steps strobe, send, release, receive and end phases one request at a time,
// reading display bytes from lkd_dispbuf ahead of use. Depends on lkd_pkg.
module lkd_seq #(
	parameter int DISPLAY_BYTES = lkd_pkg::DISPLAY_BYTES_DEF,
	parameter int KEY_BYTES     = lkd_pkg::KEY_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [1:0]    func,
	input  logic [3:0]    byte_index,
	input  logic [7:0]    byte_value,
	input  logic          din_level,
	input  lkd_pkg::cfg_t cfg,
	output lkd_pkg::res_t res,
	output logic          busy
);
	import lkd_pkg::*;

	localparam int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;
	localparam int SW = $clog2(DISPLAY_BYTES + 5);
	localparam int KW = $clog2(KEY_BYTES + 1);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_STROBE  = 3'd1;
	localparam logic [2:0] PH_SEND    = 3'd2;
	localparam logic [2:0] PH_RELEASE = 3'd3;
	localparam logic [2:0] PH_RECV    = 3'd4;
	localparam logic [2:0] PH_END     = 3'd5;

	logic [2:0]    phase_q, phase_n;
	logic [1:0]    tick_q, tick_n;
	logic [2:0]    bitc_q, bitc_n;
	logic [KW-1:0] bytec_q, bytec_n;
	logic [SW-1:0] stage_q, stage_n, stage_inc, len, rd_idx;
	logic          key_q, key_n;
	logic [7:0]    shift_q, shift_n, strobe_byte, rdata, shift_in;
	logic [3:0]    pins_q, pins_n;
	logic          kv;
	logic [KW-1:0] kidx;
	logic [7:0]    kbyte;
	logic          rej;
	logic          we;
	logic [AW-1:0] raddr;

	assign len = ({1'b0, cfg.length} > 5'(DISPLAY_BYTES)) ? SW'(DISPLAY_BYTES)
		: SW'(cfg.length);
	assign stage_inc = stage_q + SW'(1);
	assign rd_idx = stage_q - SW'(2);
	assign raddr = (stage_q >= SW'(2) && rd_idx < SW'(DISPLAY_BYTES)) ? rd_idx[AW-1:0] : '0;
	assign we = en && func == FUNC_LOAD && phase_q == PH_IDLE
		&& {1'b0, byte_index} < 5'(DISPLAY_BYTES);
	assign shift_in = shift_q | {din_level, 7'd0};

	always_comb begin
		if (key_q) begin
			strobe_byte = CMD_KEY_READ;
		end else if (stage_q == SW'(0)) begin
			strobe_byte = cfg.mode_cmd;
		end else if (stage_q == SW'(1)) begin
			strobe_byte = CMD_WRITE_AUTO;
		end else if (stage_q == SW'(2)) begin
			strobe_byte = CMD_ADDR_ZERO;
		end else begin
			strobe_byte = CMD_DISP_CTRL | {4'd0, cfg.bright};
		end
	end

	lkd_dispbuf #(.DISPLAY_BYTES(DISPLAY_BYTES), .AW(AW)) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (byte_index[AW-1:0]),
		.wdata (byte_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// pins are {stb, drive, dio, clk}
	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		bitc_n  = bitc_q;
		bytec_n = bytec_q;
		stage_n = stage_q;
		key_n   = key_q;
		shift_n = shift_q;
		pins_n  = pins_q;
		kv      = 1'b0;
		kidx    = '0;
		kbyte   = 8'd0;
		rej     = 1'b0;
		if (en) begin
			if (func == FUNC_TICK) begin
				case (phase_q)
					PH_STROBE: begin
						pins_n  = 4'b1100;
						shift_n = strobe_byte;
						bitc_n  = 3'd0;
						tick_n  = 2'd0;
						phase_n = PH_SEND;
					end
					PH_SEND: begin
						if (tick_q == 2'd0) begin
							pins_n = {2'b01, shift_q[0], 1'b0};
							tick_n = 2'd1;
						end else begin
							pins_n  = {pins_q[3:1], 1'b1};
							shift_n = {1'b0, shift_q[7:1]};
							tick_n  = 2'd0;
							bitc_n  = bitc_q + 3'd1;
							if (bitc_q == 3'd7) begin
								bitc_n = 3'd0;
								if (key_q) begin
									phase_n = PH_RELEASE;
								end else begin
									stage_n = stage_inc;
									if (stage_inc < SW'(3)) begin
										phase_n = PH_STROBE;
									end else if (stage_inc < len + SW'(3)) begin
										shift_n = rdata;
										phase_n = PH_SEND;
									end else if (stage_inc == len + SW'(3)) begin
										phase_n = PH_STROBE;
									end else begin
										phase_n = PH_END;
									end
								end
							end
						end
					end
					PH_RELEASE: begin
						pins_n  = 4'b0000;
						bitc_n  = 3'd0;
						tick_n  = 2'd0;
						bytec_n = '0;
						shift_n = 8'd0;
						phase_n = PH_RECV;
					end
					PH_RECV: begin
						if (tick_q == 2'd0) begin
							pins_n  = {pins_q[3:1], 1'b0};
							shift_n = {1'b0, shift_q[7:1]};
							tick_n  = 2'd1;
						end else if (tick_q == 2'd1) begin
							pins_n = {pins_q[3:1], 1'b1};
							tick_n = 2'd2;
						end else begin
							shift_n = shift_in;
							tick_n  = 2'd0;
							bitc_n  = bitc_q + 3'd1;
							if (bitc_q == 3'd7) begin
								kv      = 1'b1;
								kidx    = bytec_q;
								kbyte   = shift_in;
								bytec_n = bytec_q + KW'(1);
								bitc_n  = 3'd0;
								shift_n = 8'd0;
								if (bytec_q + KW'(1) >= KW'(KEY_BYTES)) begin
									phase_n = PH_END;
								end
							end
						end
					end
					PH_END: begin
						pins_n  = 4'b1100;
						phase_n = PH_IDLE;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end else if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else if (func != FUNC_LOAD) begin
				key_n   = (func == FUNC_KEY);
				stage_n = '0;
				bytec_n = '0;
				bitc_n  = 3'd0;
				tick_n  = 2'd0;
				pins_n  = 4'b1100;
				shift_n = (func == FUNC_KEY) ? CMD_KEY_READ : cfg.mode_cmd;
				phase_n = PH_SEND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 2'd0;
			bitc_q  <= 3'd0;
			bytec_q <= '0;
			stage_q <= '0;
			key_q   <= 1'b0;
			shift_q <= 8'd0;
			pins_q  <= 4'b1100;
		end else begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bitc_q  <= bitc_n;
			bytec_q <= bytec_n;
			stage_q <= stage_n;
			key_q   <= key_n;
			shift_q <= shift_n;
			pins_q  <= pins_n;
		end
	end

	assign busy = (phase_q != PH_IDLE);

	always_comb begin
		res.clk_level = pins_n[0];
		res.dio_level = pins_n[1];
		res.dio_drive = pins_n[2];
		res.stb_level = pins_n[3];
		res.busy_res  = (phase_n != PH_IDLE);
		res.rejected  = rej;
		res.key_valid = kv;
		res.key_index = KEY_IDX_W'(kidx);
		res.key_byte  = kbyte;
	end

endmodule

// ===== rtl/lkd_skid.sv =====
// Two-entry output register of the LED driver serial master.
// Decouples the result channel from the sequencer so a stalled receiver does not stop intake while an entry is free.
// Depends on lkd_pkg.
module lkd_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lkd_pkg::res_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output lkd_pkg::res_t out_data
);
	import lkd_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;

	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/led_key_driver_serial_master.sv =====
// Pin-level master for a three-wire LED driver and key-scan chip (CLK, DIO, STB).
// Requests arrive on the s_axis channel: tuser carries the function (tick, load
// display byte, start display update, start key read), tdata the buffer index,
// segment byte and sampled DIO level. Each request yields exactly one result on
// m_axis: pin levels after the request, busy, rejected and any completed key byte.
// A display update clocks its command and data bytes out at two ticks per bit; a
// key read clocks five bytes in at three ticks per bit. Loads and starts during a
// transaction are refused and flagged.
// One request is taken per cycle while s_axis_tready is high; its result is registered
// in the output register. The sequencer state is updated once per request, and display
// bytes are fetched from the registered buffer read port ahead of use.
// A two-entry output register keeps s_axis_tready high while one result waits,
// so a stalled receiver stops intake only after two results are held.
// Reset puts the pins at CLK low, DIO driven low and STB high, the sequencer idle and
// the registers at mode 0, brightness 8 and length 14. The display buffer holds no
// defined content until loaded. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, which it does not enforce.
module led_key_driver_serial_master #(
	parameter int DISPLAY_BYTES = lkd_pkg::DISPLAY_BYTES_DEF,
	parameter int KEY_BYTES     = lkd_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // byte_index[3:0], byte_value[11:4], din_level[12]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [lkd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// clk_level[0], dio_level[1], dio_drive[2], stb_level[3], busy_res[4],
	// rejected[5], key_valid[6], key_index[9:7], key_byte[17:10]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lkd_pkg::*;

	cfg_t cfg_q;
	res_t res, out_res;
	logic accept, busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_cmd <= 8'd0;
			cfg_q.bright   <= 4'd8;
			cfg_q.length   <= 4'd14;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   cfg_q.mode_cmd <= cfg_data;
				CFG_BRIGHT: cfg_q.bright   <= cfg_data[3:0];
				CFG_LENGTH: cfg_q.length   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	lkd_seq #(.DISPLAY_BYTES(DISPLAY_BYTES), .KEY_BYTES(KEY_BYTES)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.func       (s_axis_tuser),
		.byte_index (s_axis_tdata[3:0]),
		.byte_value (s_axis_tdata[11:4]),
		.din_level  (s_axis_tdata[12]),
		.cfg        (cfg_q),
		.res        (res),
		.busy       (busy)
	);

	lkd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), out_res};

	a_rej_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.rejected |-> busy && s_axis_tuser != FUNC_TICK)
		else $error("request refused while the sequencer was idle");

	a_key_released: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.key_valid |-> !res.dio_drive && res.busy_res)
		else $error("key byte reported while DIO was driven");

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !res.busy_res |-> res.stb_level && res.dio_drive && !res.clk_level)
		else $error("idle sequencer left the pins outside their rest levels");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && busy && s_axis_tuser != FUNC_TICK |=> $past(res.rejected))
		else $error("load or start during a transaction was not refused");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for led_key_driver_serial_master.
// Predicts every result from its own model of the pin sequencer and compares field by field.
// Depends on lkd_pkg and the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lkd_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_STROBE, SEQ_SEND, SEQ_RELEASE, SEQ_RECV, SEQ_END
	} seq_phase_t;

	typedef enum int {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = FUNC_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MODE;
	logic [7:0]  cfg_data = '0;

	bit quiet = 1'b0;
	int errors = 0;
	int results_seen = 0;
	res_t pin_states_due[$];

	// Predicted state of the block
	logic [7:0] segments [DISPLAY_BYTES_DEF];
	logic [7:0] mode_cmd_q = 8'h00;
	logic [3:0] bright_q = 4'd8;
	logic [3:0] length_q = 4'd14;
	seq_phase_t phase = SEQ_IDLE;
	logic [1:0] tick_ph = '0;
	int bit_cnt = 0;
	int byte_cnt = 0;
	int stage = 0;
	bit key_mode = 1'b0;
	logic [7:0] shreg = '0;
	logic pin_clk = 1'b0, pin_dio = 1'b0, pin_drive = 1'b1, pin_stb = 1'b1;
	logic key_seen = 1'b0;
	logic [2:0] key_num = '0;
	logic [7:0] key_val = '0;

	led_key_driver_serial_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int frame_data_len();
		return (length_q > DISPLAY_BYTES_DEF) ? DISPLAY_BYTES_DEF : int'(length_q);
	endfunction

	function automatic logic [7:0] frame_byte();
		if (key_mode)
			return CMD_KEY_READ;
		if (stage == 0)
			return mode_cmd_q;
		if (stage == 1)
			return CMD_WRITE_AUTO;
		if (stage == 2)
			return CMD_ADDR_ZERO;
		if (stage < 3 + frame_data_len())
			return segments[stage - 3];
		return CMD_DISP_CTRL | {4'h0, bright_q};
	endfunction

	function automatic void byte_shifted_out();
		bit_cnt = 0;
		tick_ph = '0;
		if (key_mode) begin
			phase = SEQ_RELEASE;
		end else begin
			stage++;
			if (stage < 3) begin
				phase = SEQ_STROBE;
			end else if (stage < 3 + frame_data_len()) begin
				shreg = frame_byte();
				phase = SEQ_SEND;
			end else if (stage == 3 + frame_data_len()) begin
				phase = SEQ_STROBE;
			end else begin
				phase = SEQ_END;
			end
		end
	endfunction

	function automatic void advance_sequencer(input logic din);
		case (phase)
			SEQ_STROBE: begin
				{pin_clk, pin_dio, pin_drive, pin_stb} = 4'b0011;
				shreg = frame_byte();
				bit_cnt = 0;
				tick_ph = '0;
				phase = SEQ_SEND;
			end
			SEQ_SEND: begin
				if (tick_ph == 0) begin
					pin_clk = 1'b0;
					pin_dio = shreg[0];
					pin_drive = 1'b1;
					pin_stb = 1'b0;
					tick_ph = 2'd1;
				end else begin
					pin_clk = 1'b1;
					shreg = shreg >> 1;
					tick_ph = '0;
					bit_cnt++;
					if (bit_cnt >= 8)
						byte_shifted_out();
				end
			end
			SEQ_RELEASE: begin
				{pin_clk, pin_dio, pin_drive, pin_stb} = 4'b0000;
				bit_cnt = 0;
				tick_ph = '0;
				byte_cnt = 0;
				shreg = '0;
				phase = SEQ_RECV;
			end
			SEQ_RECV: begin
				if (tick_ph == 0) begin
					pin_clk = 1'b0;
					shreg = shreg >> 1;
					tick_ph = 2'd1;
				end else if (tick_ph == 1) begin
					pin_clk = 1'b1;
					tick_ph = 2'd2;
				end else begin
					if (din)
						shreg[7] = 1'b1;
					tick_ph = '0;
					bit_cnt++;
					if (bit_cnt >= 8) begin
						key_seen = 1'b1;
						key_num = byte_cnt[2:0];
						key_val = shreg;
						byte_cnt++;
						bit_cnt = 0;
						shreg = '0;
						if (byte_cnt >= KEY_BYTES_DEF)
							phase = SEQ_END;
					end
				end
			end
			SEQ_END: begin
				{pin_clk, pin_dio, pin_drive, pin_stb} = 4'b0011;
				phase = SEQ_IDLE;
			end
			default: begin
				phase = SEQ_IDLE;
			end
		endcase
	endfunction

	function automatic res_t predict_pins(input logic [1:0] func, input logic [3:0] idx,
			input logic [7:0] val, input logic din);
		res_t r;
		logic busy;
		r = '0;
		busy = (phase != SEQ_IDLE);
		key_seen = 1'b0;
		key_num = '0;
		key_val = '0;
		if (func == FUNC_TICK) begin
			if (busy)
				advance_sequencer(din);
		end else if (busy) begin
			r.rejected = 1'b1;
		end else if (func == FUNC_LOAD) begin
			if (idx < DISPLAY_BYTES_DEF)
				segments[idx] = val;
		end else begin
			key_mode = (func == FUNC_KEY);
			stage = 0;
			byte_cnt = 0;
			bit_cnt = 0;
			tick_ph = '0;
			phase = SEQ_STROBE;
			advance_sequencer(din);
		end
		r.clk_level = pin_clk;
		r.dio_level = pin_dio;
		r.dio_drive = pin_drive;
		r.stb_level = pin_stb;
		r.busy_res = (phase != SEQ_IDLE);
		r.key_valid = key_seen;
		r.key_index = key_num;
		r.key_byte = key_val;
		return r;
	endfunction

	task automatic report(input string what);
		errors++;
		$display("%0t ns: result %0d: %s", $time, results_seen, what);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[RES_W-1:0];
			if (pin_states_due.size() == 0) begin
				report("result arrived with no request outstanding");
			end else begin
				want = pin_states_due.pop_front();
				check_field("clk_level", int'(got.clk_level), int'(want.clk_level));
				check_field("dio_level", int'(got.dio_level), int'(want.dio_level));
				check_field("dio_drive", int'(got.dio_drive), int'(want.dio_drive));
				check_field("stb_level", int'(got.stb_level), int'(want.stb_level));
				check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
				check_field("rejected", int'(got.rejected), int'(want.rejected));
				check_field("key_valid", int'(got.key_valid), int'(want.key_valid));
				check_field("key_index", int'(got.key_index), int'(want.key_index));
				check_field("key_byte", int'(got.key_byte), int'(want.key_byte));
			end
			results_seen++;
		end
	end

	always @(posedge clk)
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);

	task automatic send_item(input logic [1:0] func, input logic [3:0] idx,
			input logic [7:0] val, input logic din);
		while (!quiet && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {3'b000, din, val, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pin_states_due.push_back(predict_pins(func, idx, val, din));
	endtask

	task automatic finish_transaction(input din_pattern_t pattern);
		logic din;
		while (phase != SEQ_IDLE) begin
			case (pattern)
				DIN_LOW: din = 1'b0;
				DIN_HIGH: din = 1'b1;
				default: din = 1'($urandom_range(0, 1));
			endcase
			send_item(FUNC_TICK, 4'($urandom), 8'($urandom), din);
		end
	endtask

	task automatic set_config(input logic [7:0] mode, input logic [3:0] bright,
			input logic [3:0] len);
		s_axis_tvalid <= 1'b0;
		while (pin_states_due.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODE;
		cfg_data <= mode;
		@(posedge clk);
		cfg_index <= CFG_BRIGHT;
		cfg_data <= {4'h0, bright};
		@(posedge clk);
		cfg_index <= CFG_LENGTH;
		cfg_data <= {4'h0, len};
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_cmd_q = mode;
		bright_q = bright;
		length_q = len;
	endtask

	task automatic test_idle_and_loads();
		send_item(FUNC_TICK, 4'hF, 8'hFF, 1'b1);
		send_item(FUNC_TICK, 4'h0, 8'h00, 1'b0);
		for (int i = 0; i < DISPLAY_BYTES_DEF; i++) begin
			case (i)
				0: send_item(FUNC_LOAD, 4'(i), 8'h00, 1'b0);
				1: send_item(FUNC_LOAD, 4'(i), 8'hFF, 1'b1);
				2: send_item(FUNC_LOAD, 4'(i), 8'h01, 1'b0);
				3: send_item(FUNC_LOAD, 4'(i), 8'h80, 1'b1);
				default: send_item(FUNC_LOAD, 4'(i), 8'($urandom), 1'($urandom_range(0, 1)));
			endcase
		end
		send_item(FUNC_LOAD, 4'd14, 8'hAA, 1'b1);
		send_item(FUNC_LOAD, 4'd15, 8'h55, 1'b0);
	endtask

	task automatic test_display_update();
		quiet = 1'b1;
		send_item(FUNC_UPD, 4'h0, 8'h00, 1'b0);
		finish_transaction(DIN_RANDOM);
		quiet = 1'b0;
		set_config(8'hFF, 4'hF, 4'hF);
		send_item(FUNC_UPD, 4'hF, 8'hFF, 1'b1);
		finish_transaction(DIN_HIGH);
		set_config(8'h00, 4'h0, 4'h0);
		send_item(FUNC_UPD, 4'h3, 8'h5A, 1'b0);
		finish_transaction(DIN_LOW);
		set_config(8'h8A, 4'h7, 4'd1);
		send_item(FUNC_UPD, 4'h0, 8'h00, 1'b0);
		finish_transaction(DIN_RANDOM);
	endtask

	task automatic test_key_read();
		send_item(FUNC_KEY, 4'h0, 8'h00, 1'b0);
		finish_transaction(DIN_LOW);
		send_item(FUNC_KEY, 4'hF, 8'hFF, 1'b1);
		finish_transaction(DIN_HIGH);
		send_item(FUNC_KEY, 4'h5, 8'hA5, 1'b1);
		finish_transaction(DIN_RANDOM);
	endtask

	task automatic test_busy_refusal();
		set_config(8'h03, 4'hC, 4'd2);
		send_item(FUNC_UPD, 4'h0, 8'h00, 1'b0);
		repeat (5)
			send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		send_item(FUNC_LOAD, 4'h0, 8'hC3, 1'b0);
		send_item(FUNC_UPD, 4'h1, 8'h11, 1'b1);
		send_item(FUNC_KEY, 4'h2, 8'h22, 1'b0);
		finish_transaction(DIN_RANDOM);
		send_item(FUNC_KEY, 4'h0, 8'h00, 1'b0);
		repeat (40)
			send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		send_item(FUNC_LOAD, 4'h1, 8'h3C, 1'b1);
		send_item(FUNC_UPD, 4'h0, 8'h00, 1'b0);
		send_item(FUNC_KEY, 4'h0, 8'h00, 1'b1);
		finish_transaction(DIN_RANDOM);
		send_item(FUNC_UPD, 4'h0, 8'h00, 1'b0);
		finish_transaction(DIN_RANDOM);
	endtask

	task automatic test_random_traffic();
		int counted;
		int pick;
		logic [7:0] mode;
		logic [3:0] len;
		counted = 0;
		while (counted < 120) begin
			if ($urandom_range(99) < 40) begin
				pick = $urandom_range(0, 2);
				mode = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
				pick = $urandom_range(0, 9);
				len = (pick < 7) ? 4'($urandom_range(0, 3)) :
					(pick == 7) ? 4'd14 : (pick == 8) ? 4'd15 : 4'($urandom);
				set_config(mode, 4'($urandom_range(0, 15)), len);
			end
			repeat ($urandom_range(0, 3)) begin
				send_item(FUNC_LOAD, 4'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
				counted++;
			end
			if ($urandom_range(9) == 0)
				send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
			send_item($urandom_range(0, 1) ? FUNC_UPD : FUNC_KEY, 4'($urandom), 8'($urandom),
				1'($urandom_range(0, 1)));
			counted++;
			while (phase != SEQ_IDLE) begin
				if ($urandom_range(99) < 5) begin
					send_item(2'($urandom_range(1, 3)), 4'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
				end else begin
					send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
					counted++;
				end
			end
		end
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_loads();
		test_display_update();
		test_key_read();
		test_busy_refusal();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		while (pin_states_due.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (errors == 0)
			$display("led_key_driver_serial_master test passed");
		else
			$display("led_key_driver_serial_master test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("led_key_driver_serial_master test failed");
		$finish;
	end

endmodule
